FILE: hdl/min_coin_change_dp_unit_defines.svh
// Assertion macros shared by the min coin change unit.
// Included by the controller and datapath; no other dependencies.
`ifndef MIN_COIN_CHANGE_DP_UNIT_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_UNIT_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MCCD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mccd_pkg.sv
// Shared types and constants for the min coin change unit.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package mccd_pkg;

    localparam int VAL_W      = 10;   // amount, coin and count width
    localparam int ENTRY_W    = 11;   // table entry: reachable bit over count
    localparam int CFG_ADDR_W = 2;
    localparam int COIN_SEL_W = 3;    // selects up to eight coins; only three have registers

    localparam logic [COIN_SEL_W-1:0] NUM_COIN_REGS = 3'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_COIN_FIRST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COIN_SECOND = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COIN_THIRD  = 2'd2;

    localparam logic [VAL_W-1:0] COIN_FIRST_RST  = 10'd1;
    localparam logic [VAL_W-1:0] COIN_SECOND_RST = 10'd2;
    localparam logic [VAL_W-1:0] COIN_THIRD_RST  = 10'd3;

    typedef struct packed {
        logic                  load;      // capture amount, restart walk
        logic                  init;      // write entry zero
        logic                  rd_en;     // look up entry at i minus coin
        logic [COIN_SEL_W-1:0] coin_sel;
        logic                  wr_en;     // write entry i, advance i
        logic                  out_load;  // move result to output register
    } t_dp_cmd;

    typedef struct packed {
        logic skip_walk;   // amount zero or beyond table
        logic last_entry;  // entry i is the requested amount
        logic out_free;    // output register can take a word
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/mccd_ctrl.sv
// Sequencer for the min coin change unit: walks amounts and coins.
// Depends on mccd_pkg and the assertion macro header.
`default_nettype none

`include "min_coin_change_dp_unit_defines.svh"

module mccd_ctrl #(
    parameter int NUM_COINS = 3
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  mccd_pkg::t_dp_status i_status,
    output mccd_pkg::t_dp_cmd    o_cmd
);
    import mccd_pkg::*;

    localparam int JW = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam logic [JW-1:0] LAST_J = JW'(NUM_COINS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ZERO  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [JW-1:0] r_j, n_j;
    logic          accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.coin_sel = COIN_SEL_W'(r_j);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.init = 1'b1;
                n_j        = '0;
                n_state    = i_status.skip_walk ? S_OUT : S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (r_j == LAST_J) begin
                    n_state = S_WRITE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_WRITE: begin
                // last lookup lands this cycle; write waits for it so every coin is folded in
                o_cmd.wr_en = 1'b1;
                n_j         = '0;
                n_state     = i_status.last_entry ? S_OUT : S_READ;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

    `MCCD_ASSERT_NEXT(a_accept_starts_walk, accept, r_state == S_ZERO,
        "accepted word did not start a table walk")
    `MCCD_ASSERT_NEXT(a_last_coin_writes, (r_state == S_READ) && (r_j == LAST_J),
        r_state == S_WRITE, "entry not written after last coin lookup")

endmodule

`default_nettype wire

FILE: hdl/mccd_dpath.sv
// Datapath for the min coin change unit: coin registers, scratch table,
// running minimum and output register. Depends on mccd_pkg and the macro header.
`default_nettype none

`include "min_coin_change_dp_unit_defines.svh"

module mccd_dpath #(
    parameter int MAX_AMOUNT = 1023
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [mccd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [mccd_pkg::VAL_W-1:0]          i_cfg_wdata,
    input  wire  [mccd_pkg::VAL_W-1:0]          i_amount,
    input  wire                                 i_out_ready,
    input  mccd_pkg::t_dp_cmd                   i_cmd,
    output mccd_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [mccd_pkg::VAL_W-1:0]          o_min_coins,
    output logic                                o_reachable
);
    import mccd_pkg::*;

    // amounts are 10 bits, so the table never needs more than 1024 entries
    localparam int TOP   = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
    localparam int DEPTH = TOP + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [VAL_W-1:0] TOP_V = VAL_W'(TOP);

    logic [VAL_W-1:0]   r_coin [3];
    logic [VAL_W-1:0]   r_amount;
    logic [VAL_W-1:0]   r_i;
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_pend;
    logic               r_found;
    logic [VAL_W-1:0]   r_best;
    logic [ENTRY_W-1:0] r_res;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_min_coins;
    logic               r_reachable;

    logic [VAL_W-1:0]   coin_val;
    logic               coin_ok;
    logic [VAL_W-1:0]   diff;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               mem_we;
    logic [ENTRY_W-1:0] wdata;
    logic               take;
    logic [VAL_W-1:0]   cand;
    logic               better;
    logic               acc_found;
    logic [VAL_W-1:0]   acc_best;
    logic [ENTRY_W-1:0] final_entry;
    logic               too_big;

    // coins past the three registers read as unused
    assign coin_val = (i_cmd.coin_sel < NUM_COIN_REGS) ? r_coin[i_cmd.coin_sel[1:0]] : '0;
    assign coin_ok  = (coin_val != '0) && (coin_val <= r_i);
    assign diff     = r_i - coin_val;
    assign raddr    = diff[AW-1:0];

    // fold the lookup that came back this cycle into the running minimum
    assign take      = r_pend && r_rdata[ENTRY_W-1];
    assign cand      = r_rdata[VAL_W-1:0] + 1'b1;
    assign better    = take && (!r_found || (cand < r_best));
    assign acc_found = r_found || take;
    assign acc_best  = better ? cand : r_best;
    assign final_entry = acc_found ? {1'b1, acc_best} : '0;

    assign too_big = (r_amount > TOP_V);
    assign mem_we  = i_cmd.init || i_cmd.wr_en;
    assign waddr   = i_cmd.init ? '0 : r_i[AW-1:0];
    assign wdata   = i_cmd.init ? {1'b1, {VAL_W{1'b0}}} : final_entry;

    assign o_status.skip_walk  = (r_amount == '0) || too_big;
    assign o_status.last_entry = (r_i == r_amount);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_min_coins = r_min_coins;
    assign o_reachable = r_reachable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin[0] <= COIN_FIRST_RST;
            r_coin[1] <= COIN_SECOND_RST;
            r_coin[2] <= COIN_THIRD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COIN_FIRST:  r_coin[0] <= i_cfg_wdata;
                CFG_COIN_SECOND: r_coin[1] <= i_cfg_wdata;
                CFG_COIN_THIRD:  r_coin[2] <= i_cfg_wdata;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // scratch table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_en && coin_ok;
            if (i_cmd.init || i_cmd.wr_en) begin
                r_found <= 1'b0;
            end else if (i_cmd.rd_en) begin
                r_found <= acc_found;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= acc_best;
        if (i_cmd.load) begin
            r_amount <= i_amount;
        end
        if (i_cmd.load) begin
            r_i <= VAL_W'(1);
        end else if (i_cmd.wr_en) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.init) begin
            r_res <= too_big ? '0 : {1'b1, {VAL_W{1'b0}}};
        end else if (i_cmd.wr_en) begin
            r_res <= final_entry;
        end
        if (i_cmd.out_load) begin
            r_min_coins <= r_res[VAL_W-1:0];
            r_reachable <= r_res[ENTRY_W-1];
        end
    end

    `MCCD_ASSERT_ALWAYS(a_read_below_entry, !(i_cmd.rd_en && coin_ok) || (diff < r_i),
        "table lookup at or above the entry being built")
    `MCCD_ASSERT_ALWAYS(a_count_bounded,
        !(i_cmd.wr_en && acc_found) || (acc_best <= r_i),
        "coin count exceeds the amount")

endmodule

`default_nettype wire

FILE: hdl/min_coin_change_dp_unit.sv
// Min coin change unit: fewest coins from three configured denominations.
// After accept the unit writes entry zero, then builds entries 1 to A, A = amount,
// then waits for the output register; amount zero or above MAX_AMOUNT skips the walk.
// One word at a time: the next word is accepted from the cycle output valid rises.
// Each amount costs one table lookup per coin on the single read port plus one write.
// Reset (synchronous, active low) restores coins 1, 2, 3 and idles; no table clearing.
`default_nettype none

module min_coin_change_dp_unit #(
    parameter int MAX_AMOUNT = 1023,
    parameter int NUM_COINS  = 3
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [mccd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire  [mccd_pkg::VAL_W-1:0]      i_cfg_wdata,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [mccd_pkg::VAL_W-1:0]      i_amount,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [mccd_pkg::VAL_W-1:0]      o_min_coins,
    output logic                            o_reachable
);
    import mccd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mccd_ctrl #(
        .NUM_COINS (NUM_COINS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mccd_dpath #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_amount    (i_amount),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_min_coins (o_min_coins),
        .o_reachable (o_reachable)
    );

endmodule

`default_nettype wire
